### hw/rtl/tdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline table package
// Command and result codes, field widths and limits shared by the table files.
// ----------------------------------------------------------------------------
package tdt_pkg;

   localparam int CMD_W  = 2;
   localparam int TIME_W = 48;
   localparam int IVL_W  = 32;
   localparam int SLOT_W = 4;
   localparam int TAG_W  = 32;
   localparam int KIND_W = 3;

   localparam int MAX_RESULTS = 16;
   localparam int ORD_W       = $clog2(MAX_RESULTS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [KIND_W-1:0] kind_type;

   localparam cmd_type CMD_ADD    = 2'd0;
   localparam cmd_type CMD_CANCEL = 2'd1;
   localparam cmd_type CMD_TICK   = 2'd2;

   localparam kind_type KIND_ADDED     = 3'd0;
   localparam kind_type KIND_FULL      = 3'd1;
   localparam kind_type KIND_CANCELLED = 3'd2;
   localparam kind_type KIND_NO_MATCH  = 3'd3;
   localparam kind_type KIND_EXPIRED   = 3'd4;
   localparam kind_type KIND_NONE      = 3'd5;

endpackage

### hw/rtl/tdt_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot store
// Deadline, reload interval and tag memories: one write address, one shared
// read address, registered read data.
// ----------------------------------------------------------------------------
module tdt_slot_store #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                wr_dl_en,
   input  logic                                wr_meta_en,
   input  logic [$clog2(TIMER_SLOTS)-1:0]      wr_addr,
   input  logic [tdt_pkg::TIME_W-1:0]          wr_dl,
   input  logic [tdt_pkg::IVL_W-1:0]           wr_ivl,
   input  logic [tdt_pkg::TAG_W-1:0]           wr_tag,
   input  logic [$clog2(TIMER_SLOTS)-1:0]      rd_addr,
   output logic [tdt_pkg::TIME_W-1:0]          rd_dl,
   output logic [tdt_pkg::IVL_W-1:0]           rd_ivl,
   output logic [tdt_pkg::TAG_W-1:0]           rd_tag
);

   logic [tdt_pkg::TIME_W-1:0] dl_mem  [TIMER_SLOTS];
   logic [tdt_pkg::IVL_W-1:0]  ivl_mem [TIMER_SLOTS];
   logic [tdt_pkg::TAG_W-1:0]  tag_mem [TIMER_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_dl_en || wr_meta_en) begin
         dl_mem[wr_addr] <= wr_dl;
      end
      rd_dl <= dl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_meta_en) begin
         ivl_mem[wr_addr] <= wr_ivl;
      end
      rd_ivl <= ivl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_meta_en) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      rd_tag <= tag_mem[rd_addr];
   end

endmodule

### hw/rtl/timer_deadline_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline table
// Ordered timer queue with periodic reload over a table of timer slots.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy then stays
// high until the cycle in which the last result word is shown. Result words
// appear on the rsp_ ports for one cycle each, flagged by rsp_valid, and cannot
// be held off, so the receiver must take every word as it comes. All work goes
// through one slot memory read port and one deadline compare unit, scanning
// one slot a cycle. An add makes one scan pass for a free slot and the current
// earliest deadline; a cancel reads and checks the slot, then makes a
// next-deadline pass. A tick makes one selection pass per expired timer and a
// final empty one, rearms or disarms each timer with a read and a write, makes
// the next-deadline pass and gives each result word with a read and an output
// step. A tick with nothing due gives a single result word, and one that
// reaches the limit of 16 expiries skips the final empty pass.
// Command code 3 is taken and dropped at once with no result.
// ----------------------------------------------------------------------------
module timer_deadline_table_top #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tdt_pkg::CMD_W-1:0]          req_command,
   input  logic [tdt_pkg::TIME_W-1:0]         req_now_us,
   input  logic [tdt_pkg::TIME_W-1:0]         req_deadline_us,
   input  logic [tdt_pkg::IVL_W-1:0]          req_interval_us,
   input  logic [tdt_pkg::SLOT_W-1:0]         req_timer_slot,
   input  logic [tdt_pkg::TAG_W-1:0]          req_timer_tag,
   output logic                               rsp_valid,
   output logic [tdt_pkg::KIND_W-1:0]         rsp_kind,
   output logic [tdt_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [tdt_pkg::TAG_W-1:0]          rsp_tag,
   output logic                               rsp_earliest_changed,
   output logic [tdt_pkg::TIME_W-1:0]         rsp_next_deadline_us,
   output logic                               rsp_queue_nonempty,
   output logic                               rsp_last
);

   localparam int IW = $clog2(TIMER_SLOTS);
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int SW = 4;

   localparam logic [SW-1:0] S_IDLE     = 4'd0;
   localparam logic [SW-1:0] S_ADD_SCAN = 4'd1;
   localparam logic [SW-1:0] S_ADD_END  = 4'd2;
   localparam logic [SW-1:0] S_CAN_RD   = 4'd3;
   localparam logic [SW-1:0] S_CAN_CHK  = 4'd4;
   localparam logic [SW-1:0] S_SEL_SCAN = 4'd5;
   localparam logic [SW-1:0] S_SEL_END  = 4'd6;
   localparam logic [SW-1:0] S_RA_RD    = 4'd7;
   localparam logic [SW-1:0] S_RA_WR    = 4'd8;
   localparam logic [SW-1:0] S_MIN_SCAN = 4'd9;
   localparam logic [SW-1:0] S_EMIT_RD  = 4'd10;
   localparam logic [SW-1:0] S_EMIT_OUT = 4'd11;

   logic [SW-1:0]                   state_ff, state_in;
   logic [CW-1:0]                   ctr_ff, ctr_in;
   logic                            found_ff, found_in;
   logic [tdt_pkg::TIME_W-1:0]      best_dl_ff, best_dl_in;
   logic [IW-1:0]                   best_idx_ff, best_idx_in;
   logic                            free_found_ff, free_found_in;
   logic [IW-1:0]                   free_idx_ff, free_idx_in;
   logic [tdt_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [tdt_pkg::ORD_W-1:0]       k_ff, k_in;
   logic [TIMER_SLOTS-1:0]          armed_ff, armed_in;
   logic [TIMER_SLOTS-1:0]          picked_ff, picked_in;
   logic [tdt_pkg::TAG_W-1:0]       tag_ctr_ff, tag_ctr_in;
   logic                            cancelled_ff, cancelled_in;
   logic [IW-1:0]                   order_ff [tdt_pkg::MAX_RESULTS];

   logic [tdt_pkg::CMD_W-1:0]       cmd_ff;
   logic [tdt_pkg::TIME_W-1:0]      now_ff;
   logic [tdt_pkg::TIME_W-1:0]      dl_ff;
   logic [tdt_pkg::IVL_W-1:0]       ivl_ff;
   logic [tdt_pkg::SLOT_W-1:0]      cslot_ff;
   logic [tdt_pkg::TAG_W-1:0]       ctag_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tdt_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [tdt_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [tdt_pkg::TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic                            rsp_ec_ff, rsp_ec_in;
   logic [tdt_pkg::TIME_W-1:0]      rsp_nd_ff, rsp_nd_in;
   logic                            rsp_ne_ff, rsp_ne_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            accept;
   logic                            order_we;
   logic [IW-1:0]                   mem_addr;
   logic                            wr_dl_en, wr_meta_en;
   logic [IW-1:0]                   wr_addr;
   logic [tdt_pkg::TIME_W-1:0]      wr_dl;
   logic [tdt_pkg::TIME_W-1:0]      rd_dl;
   logic [tdt_pkg::IVL_W-1:0]       rd_ivl;
   logic [tdt_pkg::TAG_W-1:0]       rd_tag;

   logic                            ev_on;
   logic [IW-1:0]                   ev_idx;
   logic                            ev_armed;
   logic [tdt_pkg::TIME_W-1:0]      cmp_a;
   logic                            cmp_lt;
   logic                            le_now;
   logic                            take;
   logic                            scan_end;
   logic [tdt_pkg::TAG_W-1:0]       tag_next;
   logic [IW-1:0]                   cidx;
   logic                            c_in_range;
   logic [IW-1:0]                   ord_sel;
   logic [tdt_pkg::CNT_W-1:0]       k_plus;
   logic [tdt_pkg::TIME_W:0]        rearm_sum;
   logic [tdt_pkg::TIME_W-1:0]      rearm_dl;
   logic                            earliest;
   logic [tdt_pkg::TIME_W-1:0]      next_dl;

   tdt_slot_store #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_store (
      .clock      (clock),
      .wr_dl_en   (wr_dl_en),
      .wr_meta_en (wr_meta_en),
      .wr_addr    (wr_addr),
      .wr_dl      (wr_dl),
      .wr_ivl     (ivl_ff),
      .wr_tag     (tag_next),
      .rd_addr    (mem_addr),
      .rd_dl      (rd_dl),
      .rd_ivl     (rd_ivl),
      .rd_tag     (rd_tag)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign ev_on    = (ctr_ff != '0);
   assign ev_idx   = IW'(ctr_ff - CW'(1));
   assign ev_armed = armed_ff[ev_idx];
   assign scan_end = (ctr_ff == CW'(TIMER_SLOTS));

   assign cmp_a  = (state_ff == S_ADD_END) ? dl_ff : rd_dl;
   assign cmp_lt = (cmp_a < best_dl_ff);
   assign le_now = (rd_dl <= now_ff);

   assign take = ev_on && ev_armed && (!found_ff || cmp_lt) &&
                 ((state_ff != S_SEL_SCAN) || (!picked_ff[ev_idx] && le_now));

   assign tag_next   = tag_ctr_ff + tdt_pkg::TAG_W'(1);
   assign cidx       = IW'(cslot_ff);
   assign c_in_range = (int'(cslot_ff) < TIMER_SLOTS);
   assign ord_sel    = order_ff[k_ff];
   assign k_plus     = tdt_pkg::CNT_W'(k_ff) + tdt_pkg::CNT_W'(1);

   assign rearm_sum = {1'b0, now_ff} + (tdt_pkg::TIME_W + 1)'(rd_ivl);
   assign rearm_dl  = rearm_sum[tdt_pkg::TIME_W] ? tdt_pkg::TIME_MAX :
                                                  rearm_sum[tdt_pkg::TIME_W-1:0];

   assign earliest = !found_ff || cmp_lt;
   assign next_dl  = found_ff ? best_dl_ff : '0;

   always_comb begin
      state_in      = state_ff;
      ctr_in        = ctr_ff;
      found_in      = found_ff;
      best_dl_in    = best_dl_ff;
      best_idx_in   = best_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      armed_in      = armed_ff;
      picked_in     = picked_ff;
      tag_ctr_in    = tag_ctr_ff;
      cancelled_in  = cancelled_ff;
      order_we      = 1'b0;
      mem_addr      = '0;
      wr_dl_en      = 1'b0;
      wr_meta_en    = 1'b0;
      wr_addr       = free_idx_ff;
      wr_dl         = dl_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_ec_in     = rsp_ec_ff;
      rsp_nd_in     = rsp_nd_ff;
      rsp_ne_in     = rsp_ne_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            ctr_in        = '0;
            found_in      = 1'b0;
            free_found_in = 1'b0;
            if (accept) begin
               unique case (req_command)
                  tdt_pkg::CMD_ADD:    state_in = S_ADD_SCAN;
                  tdt_pkg::CMD_CANCEL: state_in = S_CAN_RD;
                  tdt_pkg::CMD_TICK: begin
                     picked_in = '0;
                     cnt_in    = '0;
                     state_in  = S_SEL_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_ADD_SCAN, S_SEL_SCAN, S_MIN_SCAN: begin
            if (!scan_end) begin
               mem_addr = ctr_ff[IW-1:0];
            end
            if (take) begin
               found_in    = 1'b1;
               best_dl_in  = rd_dl;
               best_idx_in = ev_idx;
            end
            if ((state_ff == S_ADD_SCAN) && ev_on && !ev_armed && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = ev_idx;
            end
            ctr_in = ctr_ff + CW'(1);
            if (scan_end) begin
               ctr_in = '0;
               unique case (state_ff)
                  S_ADD_SCAN: state_in = S_ADD_END;
                  S_SEL_SCAN: state_in = S_SEL_END;
                  default: begin
                     k_in     = '0;
                     state_in = S_EMIT_RD;
                  end
               endcase
            end
         end

         S_ADD_END: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            if (free_found_ff) begin
               wr_meta_en             = 1'b1;
               wr_addr                = free_idx_ff;
               armed_in[free_idx_ff]  = 1'b1;
               tag_ctr_in             = tag_next;
               rsp_kind_in            = tdt_pkg::KIND_ADDED;
               rsp_slot_in            = tdt_pkg::SLOT_W'(free_idx_ff);
               rsp_tag_in             = tag_next;
               rsp_ec_in              = earliest;
               rsp_nd_in              = earliest ? dl_ff : best_dl_ff;
               rsp_ne_in              = 1'b1;
            end else begin
               rsp_kind_in = tdt_pkg::KIND_FULL;
               rsp_slot_in = '0;
               rsp_tag_in  = '0;
               rsp_ec_in   = 1'b0;
               rsp_nd_in   = next_dl;
               rsp_ne_in   = found_ff;
            end
            state_in = S_IDLE;
         end

         S_CAN_RD: begin
            mem_addr = cidx;
            state_in = S_CAN_CHK;
         end

         S_CAN_CHK: begin
            cancelled_in = c_in_range && armed_ff[cidx] && (rd_tag == ctag_ff);
            if (cancelled_in) begin
               armed_in[cidx] = 1'b0;
            end
            found_in = 1'b0;
            ctr_in   = '0;
            state_in = S_MIN_SCAN;
         end

         S_SEL_END: begin
            found_in = 1'b0;
            ctr_in   = '0;
            k_in     = '0;
            if (found_ff) begin
               order_we               = 1'b1;
               picked_in[best_idx_ff] = 1'b1;
               cnt_in                 = cnt_ff + tdt_pkg::CNT_W'(1);
               state_in = (cnt_in == tdt_pkg::CNT_W'(tdt_pkg::MAX_RESULTS)) ? S_RA_RD :
                                                                            S_SEL_SCAN;
            end else begin
               state_in = (cnt_ff == '0) ? S_MIN_SCAN : S_RA_RD;
            end
         end

         S_RA_RD: begin
            mem_addr = ord_sel;
            state_in = S_RA_WR;
         end

         S_RA_WR: begin
            if (rd_ivl != '0) begin
               wr_dl_en = 1'b1;
               wr_addr  = ord_sel;
               wr_dl    = rearm_dl;
            end else begin
               armed_in[ord_sel] = 1'b0;
            end
            if (k_plus == cnt_ff) begin
               found_in = 1'b0;
               ctr_in   = '0;
               state_in = S_MIN_SCAN;
            end else begin
               k_in     = k_ff + tdt_pkg::ORD_W'(1);
               state_in = S_RA_RD;
            end
         end

         S_EMIT_RD: begin
            mem_addr = ord_sel;
            state_in = S_EMIT_OUT;
         end

         S_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_ec_in    = 1'b0;
            rsp_nd_in    = next_dl;
            rsp_ne_in    = found_ff;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
            if (cmd_ff == tdt_pkg::CMD_CANCEL) begin
               rsp_kind_in = cancelled_ff ? tdt_pkg::KIND_CANCELLED :
                                            tdt_pkg::KIND_NO_MATCH;
               rsp_slot_in = cslot_ff;
               rsp_tag_in  = ctag_ff;
            end else if (cnt_ff == '0) begin
               rsp_kind_in = tdt_pkg::KIND_NONE;
               rsp_slot_in = '0;
               rsp_tag_in  = '0;
            end else begin
               rsp_kind_in = tdt_pkg::KIND_EXPIRED;
               rsp_slot_in = tdt_pkg::SLOT_W'(ord_sel);
               rsp_tag_in  = rd_tag;
               rsp_last_in = (k_plus == cnt_ff);
               if (!rsp_last_in) begin
                  k_in     = k_ff + tdt_pkg::ORD_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         armed_ff     <= '0;
         tag_ctr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         tag_ctr_ff   <= tag_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff        <= ctr_in;
      found_ff      <= found_in;
      best_dl_ff    <= best_dl_in;
      best_idx_ff   <= best_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      picked_ff     <= picked_in;
      cancelled_ff  <= cancelled_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_ec_ff     <= rsp_ec_in;
      rsp_nd_ff     <= rsp_nd_in;
      rsp_ne_ff     <= rsp_ne_in;
      rsp_last_ff   <= rsp_last_in;
      if (order_we) begin
         order_ff[cnt_ff[tdt_pkg::ORD_W-1:0]] <= best_idx_ff;
      end
      if (accept) begin
         cmd_ff   <= req_command;
         now_ff   <= req_now_us;
         dl_ff    <= req_deadline_us;
         ivl_ff   <= req_interval_us;
         cslot_ff <= req_timer_slot;
         ctag_ff  <= req_timer_tag;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_tag              = rsp_tag_ff;
   assign rsp_earliest_changed = rsp_ec_ff;
   assign rsp_next_deadline_us = rsp_nd_ff;
   assign rsp_queue_nonempty   = rsp_ne_ff;
   assign rsp_last             = rsp_last_ff;

endmodule
